// ===== sv/cd_sector_to_hunk_mapper_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sector-to-hunk mapper.
// One form with a reset qualifier and one that is checked during reset too.
// ---------------------------------------------------------------------------
`ifndef CD_SECTOR_TO_HUNK_MAPPER_UNIT_MACROS_SVH
`define CD_SECTOR_TO_HUNK_MAPPER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CSTHM_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define CSTHM_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define CSTHM_ASSERT(lbl, ck, rn, prop, msg)
`define CSTHM_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

// ===== sv/csthm_pkg.sv =====
// ---------------------------------------------------------------------------
// csthm_pkg
// Types and constants shared by the sector-to-hunk mapper modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csthm_pkg;

	localparam int REQUEST_BITS = 16;
	localparam int FRAME_BYTES  = 2448;
	localparam int MAX_CHUNKS   = 32;
	localparam int MAX_PAYLOAD  = 2352;
	localparam int QUEUE_DEPTH  = 2;

	localparam int SECTOR_W = 32;
	localparam int REQ_W    = 16;
	localparam int TRACK_W  = 20;
	localparam int FIH_W    = 8;
	localparam int SKIP_W   = 5;
	localparam int PAY_W    = 12;
	localparam int HUNK_W   = 21;
	localparam int OFFS_W   = 20;
	localparam int CNT_W    = 6;
	localparam int CFG_IDX_W = 3;

	localparam logic [REQ_W-1:0] REQ_MASK = REQ_W'((64'd1 << REQUEST_BITS) - 64'd1);
	localparam logic [FIH_W-1:0] FIH_RESET = FIH_W'(8);
	localparam logic [PAY_W-1:0] PAY_RESET = PAY_W'(2048);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRACK_ABS_START   = 3'd0,
		CFG_TRACK_FRAMES      = 3'd1,
		CFG_TRACK_IMAGE_START = 3'd2,
		CFG_FRAMES_IN_HUNK    = 3'd3,
		CFG_SKIP_BYTES        = 3'd4,
		CFG_PAYLOAD_BYTES     = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_CHECK,
		FS_PREP,
		FS_DIV,
		FS_MUL,
		FS_PUSH
	} front_state_t;

	typedef struct packed {
		logic [SECTOR_W-1:0] start_sector;
		logic [REQ_W-1:0]    request_bytes;
	} req_t;

	typedef struct packed {
		logic [HUNK_W-1:0] hunk_index;
		logic              fetch_needed;
		logic [OFFS_W-1:0] offset_in_hunk;
		logic [PAY_W-1:0]  chunk_bytes;
		logic [REQ_W-1:0]  bytes_so_far;
		logic              last_chunk;
	} res_t;

	// Effective track settings: frames per hunk is never zero and the
	// payload size is already saturated.
	typedef struct packed {
		logic [TRACK_W-1:0] track_abs_start;
		logic [TRACK_W-1:0] track_frames;
		logic [TRACK_W-1:0] track_image_start;
		logic [FIH_W-1:0]   frames_in_hunk;
		logic [SKIP_W-1:0]  skip_bytes;
		logic [PAY_W-1:0]   payload_bytes;
	} cfg_t;

	typedef struct packed {
		logic              empty;
		logic [HUNK_W-1:0] hunk;
		logic [FIH_W-1:0]  pos;
		logic [OFFS_W-1:0] pos_bytes;
		logic [REQ_W-1:0]  rem;
		logic [CNT_W-1:0]  limit;
	} desc_t;

endpackage

`default_nettype wire

// ===== sv/csthm_front.sv =====
// ---------------------------------------------------------------------------
// csthm_front
// Accepts a read request, classifies it and finds the first hunk and frame
// position with a one-bit-per-cycle divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csthm_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire csthm_pkg::req_t     req_data,
	input  wire csthm_pkg::cfg_t     cfg,
	output logic                     q_push,
	input  wire logic                q_full,
	output csthm_pkg::desc_t         q_data
);

	localparam int HW = csthm_pkg::HUNK_W;
	localparam int FW = csthm_pkg::FIH_W;
	localparam int TW = csthm_pkg::TRACK_W;
	localparam int SW = csthm_pkg::SECTOR_W;

	csthm_pkg::front_state_t state_q, state_nxt;

	logic [SW-1:0]                 start_q;
	logic [csthm_pkg::REQ_W-1:0]   rem_q;
	logic [TW-1:0]                 off_q;
	logic                          empty_q;
	logic [csthm_pkg::CNT_W-1:0]   limit_q;
	logic [HW-1:0]                 dvd_q;
	logic [FW-1:0]                 part_q;
	logic [4:0]                    step_q;
	logic [csthm_pkg::OFFS_W-1:0]  posb_q;

	logic          accept;
	logic [SW:0]   diff;
	logic          outside;
	logic          empty_nxt;
	logic [HW-1:0] frame;
	logic [TW-1:0] avail;
	logic [FW:0]   trial;
	logic          ge;
	logic [FW:0]   trial_sub;

	assign accept = push && !full;

	// The sector lies before the track when the subtraction borrows.
	assign diff      = {1'b0, start_q} - {(SW + 1 - TW)'(0), cfg.track_abs_start};
	assign outside   = diff[SW] || (diff[SW-1:0] >= {(SW - TW)'(0), cfg.track_frames});
	assign empty_nxt = outside || (rem_q == '0) || (cfg.payload_bytes == '0);

	assign frame = {1'b0, cfg.track_image_start} + {1'b0, off_q};
	assign avail = cfg.track_frames - off_q;

	assign trial     = {part_q, dvd_q[HW-1]};
	assign ge        = trial >= {1'b0, cfg.frames_in_hunk};
	assign trial_sub = trial - {1'b0, cfg.frames_in_hunk};

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			csthm_pkg::FS_IDLE: begin
				if (accept) state_nxt = csthm_pkg::FS_CHECK;
			end
			csthm_pkg::FS_CHECK: begin
				state_nxt = empty_nxt ? csthm_pkg::FS_PUSH : csthm_pkg::FS_PREP;
			end
			csthm_pkg::FS_PREP: state_nxt = csthm_pkg::FS_DIV;
			csthm_pkg::FS_DIV: begin
				if (step_q == '0) state_nxt = csthm_pkg::FS_MUL;
			end
			csthm_pkg::FS_MUL: state_nxt = csthm_pkg::FS_PUSH;
			csthm_pkg::FS_PUSH: begin
				if (!q_full) state_nxt = csthm_pkg::FS_IDLE;
			end
			default: state_nxt = csthm_pkg::FS_IDLE;
		endcase
	end

	always_comb begin
		full   = (state_q != csthm_pkg::FS_IDLE);
		q_push = (state_q == csthm_pkg::FS_PUSH) && !q_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csthm_pkg::FS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			csthm_pkg::FS_IDLE: begin
				if (accept) begin
					start_q <= req_data.start_sector;
					rem_q   <= req_data.request_bytes & csthm_pkg::REQ_MASK;
				end
			end
			csthm_pkg::FS_CHECK: begin
				off_q   <= diff[TW-1:0];
				empty_q <= empty_nxt;
			end
			csthm_pkg::FS_PREP: begin
				dvd_q   <= frame;
				part_q  <= '0;
				step_q  <= 5'(HW - 1);
				limit_q <= (avail >= TW'(csthm_pkg::MAX_CHUNKS)) ?
					csthm_pkg::CNT_W'(csthm_pkg::MAX_CHUNKS) : avail[csthm_pkg::CNT_W-1:0];
			end
			csthm_pkg::FS_DIV: begin
				// Restoring division: the quotient shifts in where the dividend leaves.
				part_q <= ge ? trial_sub[FW-1:0] : trial[FW-1:0];
				dvd_q  <= {dvd_q[HW-2:0], ge};
				step_q <= step_q - 5'd1;
			end
			csthm_pkg::FS_MUL: begin
				posb_q <= csthm_pkg::OFFS_W'(part_q) *
					csthm_pkg::OFFS_W'(csthm_pkg::FRAME_BYTES);
			end
			default: ;
		endcase
	end

	always_comb begin
		q_data           = '0;
		q_data.empty     = empty_q;
		q_data.rem       = rem_q;
		if (!empty_q) begin
			q_data.hunk      = dvd_q;
			q_data.pos       = part_q;
			q_data.pos_bytes = posb_q;
			q_data.limit     = limit_q;
		end
	end

endmodule

`default_nettype wire

// ===== sv/csthm_queue.sv =====
// ---------------------------------------------------------------------------
// csthm_queue
// Short descriptor queue between the front and the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cd_sector_to_hunk_mapper_unit_macros.svh"

module csthm_queue #(
	parameter int DEPTH = csthm_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire csthm_pkg::desc_t  wr_data,
	input  wire logic              pop,
	output logic                   empty,
	output csthm_pkg::desc_t       rd_data
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	csthm_pkg::desc_t mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`CSTHM_ASSERT_ALWAYS(a_count_bound, clk, count_q <= CntW'(DEPTH), "queue count above depth")
	`CSTHM_ASSERT(a_no_overflow, clk, arst_n, !(push && full), "push into a full queue")
	`CSTHM_ASSERT(a_pop_drains, clk, arst_n, (do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1), "pop did not drain")

endmodule

`default_nettype wire

// ===== sv/csthm_back.sv =====
// ---------------------------------------------------------------------------
// csthm_back
// Walks one descriptor sector by sector and emits a chunk per cycle into the
// result register while it is empty or popped, keeping the one-entry hunk tag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cd_sector_to_hunk_mapper_unit_macros.svh"

module csthm_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire csthm_pkg::cfg_t   cfg,
	input  wire logic              cfg_wr,
	input  wire csthm_pkg::desc_t  q_data,
	input  wire logic              q_empty,
	output logic                   q_pop,
	output csthm_pkg::res_t        res_data,
	output logic                   empty,
	input  wire logic              pop
);

	localparam int RW = csthm_pkg::REQ_W;
	localparam int FW = csthm_pkg::FIH_W;
	localparam int CW = csthm_pkg::CNT_W;

	logic                          active_q;
	logic                          empty_run_q;
	logic [csthm_pkg::HUNK_W-1:0]  hunk_q;
	logic [FW-1:0]                 pos_q;
	logic [csthm_pkg::OFFS_W-1:0]  posb_q;
	logic [RW-1:0]                 rem_q;
	logic [RW-1:0]                 total_q;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 limit_q;
	logic                          out_valid_q;
	csthm_pkg::res_t               out_q;
	logic [csthm_pkg::HUNK_W-1:0]  tag_q;
	logic                          tag_valid_q;

	logic            emit;
	logic [RW-1:0]   pay16;
	logic [RW-1:0]   want;
	logic [RW-1:0]   rem_after;
	logic [CW-1:0]   cnt_inc;
	logic            wrap;
	csthm_pkg::res_t nxt_res;

	assign emit  = active_q && (!out_valid_q || pop);
	assign q_pop = !active_q && !q_empty;

	assign pay16     = {(RW - csthm_pkg::PAY_W)'(0), cfg.payload_bytes};
	assign want      = (rem_q < pay16) ? rem_q : pay16;
	assign rem_after = rem_q - want;
	assign cnt_inc   = cnt_q + 1'b1;
	assign wrap      = ({1'b0, pos_q} + 1'b1) == {1'b0, cfg.frames_in_hunk};

	always_comb begin
		nxt_res = '0;
		nxt_res.last_chunk = 1'b1;
		if (!empty_run_q) begin
			nxt_res.hunk_index     = hunk_q;
			nxt_res.fetch_needed   = !tag_valid_q || (tag_q != hunk_q);
			nxt_res.offset_in_hunk = posb_q +
				{(csthm_pkg::OFFS_W - csthm_pkg::SKIP_W)'(0), cfg.skip_bytes};
			nxt_res.chunk_bytes    = want[csthm_pkg::PAY_W-1:0];
			nxt_res.bytes_so_far   = (total_q + want) & csthm_pkg::REQ_MASK;
			// The run ends when the bytes are used up, at the track end or at
			// the chunk limit; the limit already covers the track end.
			nxt_res.last_chunk     = (rem_after == '0) || (cnt_inc == limit_q);
		end
	end

	assign empty    = !out_valid_q;
	assign res_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			tag_valid_q <= 1'b0;
			tag_q       <= '0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
			end else if (emit && nxt_res.last_chunk) begin
				active_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (emit && !empty_run_q) begin
				tag_q <= hunk_q;
			end
			if (cfg_wr) begin
				tag_valid_q <= 1'b0;
			end else if (emit && !empty_run_q) begin
				tag_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			empty_run_q <= q_data.empty;
			hunk_q      <= q_data.hunk;
			pos_q       <= q_data.pos;
			posb_q      <= q_data.pos_bytes;
			rem_q       <= q_data.rem;
			limit_q     <= q_data.limit;
			total_q     <= '0;
			cnt_q       <= '0;
		end else if (emit) begin
			rem_q   <= rem_after;
			total_q <= total_q + want;
			cnt_q   <= cnt_inc;
			if (wrap) begin
				pos_q  <= '0;
				posb_q <= '0;
				hunk_q <= hunk_q + 1'b1;
			end else begin
				pos_q  <= pos_q + 1'b1;
				posb_q <= posb_q + csthm_pkg::OFFS_W'(csthm_pkg::FRAME_BYTES);
			end
		end
		if (emit) begin
			out_q <= nxt_res;
		end
	end

	`CSTHM_ASSERT(a_last_ends_run, clk, arst_n, (emit && nxt_res.last_chunk) |=> !active_q, "run continued after last chunk")
	`CSTHM_ASSERT(a_chunk_limit, clk, arst_n, (active_q && !empty_run_q) |-> (cnt_q < limit_q), "chunk count passed the limit")
	`CSTHM_ASSERT(a_tag_follows, clk, arst_n, (emit && !empty_run_q && !cfg_wr) |=> (tag_valid_q && (tag_q == $past(hunk_q))), "hunk tag did not follow the chunk")

endmodule

`default_nettype wire

// ===== sv/cd_sector_to_hunk_mapper_unit.sv =====
// ---------------------------------------------------------------------------
// cd_sector_to_hunk_mapper_unit
// Splits a sector read request into per-sector chunk descriptors with hunk
// index, cached-tag miss flag, offset in hunk and running byte count.
//
//   Channel   Direction  Handshake               Payload
//   request   in         push / full            req_data (start, byte count)
//   result    out        empty / pop            res_data (one chunk)
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front takes one request at a time: check, prepare, a 21-step serial divide
// by frames per hunk, one multiply and hand-off, which waits while the queue is
// full; an empty request skips prepare, divide and multiply. The back emits one
// chunk per cycle while its result register is free or popped, up to 32 per
// request, and works on one request while the front works on the next.
// Reset is asynchronous: the queue empties, the hunk tag becomes invalid and
// the registers take their reset values; no clearing pass follows.
// full stays high while the front is busy; the back waits while a result
// sits unpopped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cd_sector_to_hunk_mapper_unit #(
	parameter int QUEUE_DEPTH = csthm_pkg::QUEUE_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire csthm_pkg::req_t                   req_data,
	output logic                                   empty,
	input  wire logic                              pop,
	output csthm_pkg::res_t                        res_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [csthm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [csthm_pkg::TRACK_W-1:0]     cfg_data
);

	logic [csthm_pkg::TRACK_W-1:0] trk_base_q;
	logic [csthm_pkg::TRACK_W-1:0] frames_q;
	logic [csthm_pkg::TRACK_W-1:0] image_start_q;
	logic [csthm_pkg::FIH_W-1:0]   fih_q;
	logic [csthm_pkg::SKIP_W-1:0]  skip_q;
	logic [csthm_pkg::PAY_W-1:0]   pay_q;

	logic             cfg_fire;
	logic             cfg_wr;
	csthm_pkg::cfg_t  cfg;

	logic             q_push, q_full, q_pop, q_empty;
	csthm_pkg::desc_t q_wr_data, q_rd_data;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// Writes outside the register list are dropped and leave the tag alone.
	always_comb begin
		case (csthm_pkg::cfg_idx_t'(cfg_index))
			csthm_pkg::CFG_TRACK_ABS_START,
			csthm_pkg::CFG_TRACK_FRAMES,
			csthm_pkg::CFG_TRACK_IMAGE_START,
			csthm_pkg::CFG_FRAMES_IN_HUNK,
			csthm_pkg::CFG_SKIP_BYTES,
			csthm_pkg::CFG_PAYLOAD_BYTES: cfg_wr = cfg_fire;
			default: cfg_wr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_base_q    <= '0;
			frames_q      <= '0;
			image_start_q <= '0;
			fih_q         <= csthm_pkg::FIH_RESET;
			skip_q        <= '0;
			pay_q         <= csthm_pkg::PAY_RESET;
		end else if (cfg_fire) begin
			case (csthm_pkg::cfg_idx_t'(cfg_index))
				csthm_pkg::CFG_TRACK_ABS_START:   trk_base_q    <= cfg_data;
				csthm_pkg::CFG_TRACK_FRAMES:      frames_q      <= cfg_data;
				csthm_pkg::CFG_TRACK_IMAGE_START: image_start_q <= cfg_data;
				csthm_pkg::CFG_FRAMES_IN_HUNK:    fih_q  <= cfg_data[csthm_pkg::FIH_W-1:0];
				csthm_pkg::CFG_SKIP_BYTES:        skip_q <= cfg_data[csthm_pkg::SKIP_W-1:0];
				csthm_pkg::CFG_PAYLOAD_BYTES:     pay_q  <= cfg_data[csthm_pkg::PAY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.track_abs_start   = trk_base_q;
		cfg.track_frames      = frames_q;
		cfg.track_image_start = image_start_q;
		cfg.frames_in_hunk    = (fih_q == '0) ? csthm_pkg::FIH_W'(1) : fih_q;
		cfg.skip_bytes        = skip_q;
		cfg.payload_bytes     = (pay_q > csthm_pkg::PAY_W'(csthm_pkg::MAX_PAYLOAD)) ?
			csthm_pkg::PAY_W'(csthm_pkg::MAX_PAYLOAD) : pay_q;
	end

	csthm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req_data (req_data),
		.cfg      (cfg),
		.q_push   (q_push),
		.q_full   (q_full),
		.q_data   (q_wr_data)
	);

	csthm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.full    (q_full),
		.wr_data (q_wr_data),
		.pop     (q_pop),
		.empty   (q_empty),
		.rd_data (q_rd_data)
	);

	csthm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_wr   (cfg_wr),
		.q_data   (q_rd_data),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.res_data (res_data),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

`default_nettype wire

// ===== tb/cd_sector_to_hunk_mapper_unit_chunk_check.sv =====
// ---------------------------------------------------------------------------
// cd_sector_to_hunk_mapper_unit_chunk_check
// Watches the request, configuration and result channels of the mapper. It
// keeps its own copy of the track settings and the cached hunk tag, works out
// the chunk list of every accepted request and compares each popped chunk,
// field by field, with the oldest chunk still owed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cd_sector_to_hunk_mapper_unit_chunk_check
	import csthm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire logic                 full,
	input  wire req_t                 req_data,
	input  wire logic                 empty,
	input  wire logic                 pop,
	input  wire res_t                 res_data,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TRACK_W-1:0]   cfg_data,
	output int unsigned               failures,
	output int unsigned               chunks_due
);

	logic [TRACK_W-1:0] trk_first = '0;
	logic [TRACK_W-1:0] trk_len = '0;
	logic [TRACK_W-1:0] img_first = '0;
	logic [FIH_W-1:0]   fih = FIH_RESET;
	logic [SKIP_W-1:0]  skip = '0;
	logic [PAY_W-1:0]   payload = PAY_RESET;
	logic [HUNK_W-1:0]  tag = '0;
	logic               tag_valid = 1'b0;

	res_t        expected_chunks[$];
	int unsigned fail_tally = 0;
	int unsigned owed = 0;

	assign failures = fail_tally;
	assign chunks_due = owed;

	// Splits one request into chunks and appends them to the expected list.
	// The cached tag follows every chunk's hunk as if the hunk were fetched.
	task automatic map_request(input req_t rq);
		longint unsigned first, rem, total, sector, off, frame, want, fih_eff, pay_eff;
		int n;
		res_t ch;
		first = rq.start_sector;
		rem = rq.request_bytes & REQ_MASK;
		total = 0;
		n = 0;
		fih_eff = (fih == '0) ? 1 : fih;
		pay_eff = (payload > MAX_PAYLOAD) ? MAX_PAYLOAD : payload;
		while (n < MAX_CHUNKS && rem > 0) begin
			sector = first + n;
			if (sector < trk_first)
				break;
			off = sector - trk_first;
			if (off >= trk_len)
				break;
			want = (rem < pay_eff) ? rem : pay_eff;
			if (want == 0)
				break;
			frame = img_first + off;
			ch.hunk_index = HUNK_W'(frame / fih_eff);
			ch.fetch_needed = !tag_valid || (tag != ch.hunk_index);
			tag = ch.hunk_index;
			tag_valid = 1'b1;
			ch.offset_in_hunk = OFFS_W'((frame % fih_eff) * FRAME_BYTES + skip);
			ch.chunk_bytes = PAY_W'(want);
			total += want;
			rem -= want;
			ch.bytes_so_far = REQ_W'(total);
			ch.last_chunk = 1'b0;
			expected_chunks.push_back(ch);
			n++;
		end
		if (n == 0) begin
			// Nothing readable: a single chunk, all zero but for the last-chunk flag, closes the request.
			ch = '0;
			ch.last_chunk = 1'b1;
			expected_chunks.push_back(ch);
		end else begin
			expected_chunks[expected_chunks.size() - 1].last_chunk = 1'b1;
		end
	endtask

	function automatic bit field_differs(string label, logic [31:0] want, logic [31:0] got);
		if (want == got)
			return 1'b0;
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
		return 1'b1;
	endfunction

	task automatic check_chunk(input res_t got);
		res_t want;
		bit bad;
		if (expected_chunks.size() == 0) begin
			fail_tally++;
			$display("%0t: chunk mismatch: expected no chunk, actual %p", $time, got);
		end else begin
			want = expected_chunks.pop_front();
			bad = field_differs("hunk_index", want.hunk_index, got.hunk_index)
				| field_differs("fetch_needed", want.fetch_needed, got.fetch_needed)
				| field_differs("offset_in_hunk", want.offset_in_hunk, got.offset_in_hunk)
				| field_differs("chunk_bytes", want.chunk_bytes, got.chunk_bytes)
				| field_differs("bytes_so_far", want.bytes_so_far, got.bytes_so_far)
				| field_differs("last_chunk", want.last_chunk, got.last_chunk);
			if (bad)
				fail_tally++;
		end
	endtask

	// Every write to one of the six registers drops the cached hunk.
	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [TRACK_W-1:0] value);
		case (cfg_idx_t'(idx))
			CFG_TRACK_ABS_START: begin
				trk_first = value;
				tag_valid = 1'b0;
			end
			CFG_TRACK_FRAMES: begin
				trk_len = value;
				tag_valid = 1'b0;
			end
			CFG_TRACK_IMAGE_START: begin
				img_first = value;
				tag_valid = 1'b0;
			end
			CFG_FRAMES_IN_HUNK: begin
				fih = value[FIH_W-1:0];
				tag_valid = 1'b0;
			end
			CFG_SKIP_BYTES: begin
				skip = value[SKIP_W-1:0];
				tag_valid = 1'b0;
			end
			CFG_PAYLOAD_BYTES: begin
				payload = value[PAY_W-1:0];
				tag_valid = 1'b0;
			end
			default: ;
		endcase
	endtask

	// Chunks popped at an edge belong to earlier requests, so they are
	// checked before the request taken at the same edge is mapped.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_first = '0;
			trk_len = '0;
			img_first = '0;
			fih = FIH_RESET;
			skip = '0;
			payload = PAY_RESET;
			tag = '0;
			tag_valid = 1'b0;
			expected_chunks.delete();
		end else begin
			if (pop && !empty)
				check_chunk(res_data);
			if (cfg_valid && cfg_ready)
				write_setting(cfg_index, cfg_data);
			if (push && !full)
				map_request(req_data);
		end
		owed = expected_chunks.size();
	end

endmodule

// ===== tb/cd_sector_to_hunk_mapper_unit_test.sv =====
// ---------------------------------------------------------------------------
// cd_sector_to_hunk_mapper_unit_test
// Drives read requests and track settings into the sector-to-hunk mapper and
// pops its chunks with random gaps, a long result stall and a calm stretch.
// A directed set covers the track edges, empty requests, the chunk limit and
// the register extremes; random phases follow with fresh track settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cd_sector_to_hunk_mapper_unit_test;

	import csthm_pkg::*;

	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 45;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 500000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b1;
	logic                 push;
	logic                 full;
	req_t                 req_data;
	logic                 empty;
	logic                 pop = 1'b0;
	res_t                 res_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TRACK_W-1:0]   cfg_data;

	int unsigned failures;
	int unsigned chunks_due;
	int unsigned cycle_count = 0;

	// Current track window, used to aim random requests.
	logic [TRACK_W-1:0] cur_abs = '0;
	logic [TRACK_W-1:0] cur_frames = '0;

	bit calm = 1'b0;
	int hold_orders = 0;
	int hold_served = 0;
	int hold_left = 0;

	cd_sector_to_hunk_mapper_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req_data  (req_data),
		.empty     (empty),
		.pop       (pop),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cd_sector_to_hunk_mapper_unit_chunk_check i_chunk_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_data   (req_data),
		.empty      (empty),
		.pop        (pop),
		.res_data   (res_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.failures   (failures),
		.chunks_due (chunks_due)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: random gaps, none while calm, and a long hold on request.
	always @(negedge clk) begin
		if (hold_served != hold_orders) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
		end
		if (!arst_n) begin
			pop = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop = 1'b0;
		end else begin
			pop = calm || ($urandom_range(99) >= 12);
		end
	end

	function automatic req_t make_req(logic [SECTOR_W-1:0] sector, logic [REQ_W-1:0] count);
		req_t rq;
		rq.start_sector = sector;
		rq.request_bytes = count;
		return rq;
	endfunction

	// Mostly requests that start inside the track, some near its end, the
	// rest zero counts, sectors outside the track and raw noise.
	function automatic req_t pick_request();
		int unsigned roll, span;
		logic [SECTOR_W-1:0] sector;
		logic [REQ_W-1:0] count;
		roll = $urandom_range(99);
		span = (cur_frames == '0) ? 1 : {12'd0, cur_frames};
		sector = cur_abs + $urandom_range(0, span - 1);
		if ($urandom_range(4) == 0 && span >= 4)
			sector = cur_abs + span - $urandom_range(1, 4);
		case ($urandom_range(2))
			0: count = REQ_W'($urandom_range(1, 2400));
			1: count = REQ_W'($urandom_range(1, 20000));
			default: count = REQ_W'($urandom);
		endcase
		if (roll < 75)
			;
		else if (roll < 82)
			count = '0;
		else if (roll < 90 && cur_abs != '0)
			sector = $urandom_range(0, cur_abs - 1);
		else if (roll < 95)
			sector = cur_abs + cur_frames + $urandom_range(0, 40);
		else
			sector = $urandom;
		return make_req(sector, count);
	endfunction

	task automatic offer(input req_t rq);
		if (!calm && $urandom_range(99) < 12) begin
			push = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		push = 1'b1;
		req_data = rq;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	// Stops sending and waits until every owed chunk has been popped.
	task automatic drain();
		push = 1'b0;
		while (chunks_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [TRACK_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic program_track(input logic [TRACK_W-1:0] first_sector,
			input logic [TRACK_W-1:0] frames,
			input logic [TRACK_W-1:0] image_start, input logic [FIH_W-1:0] per_hunk,
			input logic [SKIP_W-1:0] skip, input logic [PAY_W-1:0] payload);
		drain();
		write_reg(CFG_TRACK_ABS_START, first_sector);
		write_reg(CFG_TRACK_FRAMES, frames);
		write_reg(CFG_TRACK_IMAGE_START, image_start);
		write_reg(CFG_FRAMES_IN_HUNK, TRACK_W'(per_hunk));
		write_reg(CFG_SKIP_BYTES, TRACK_W'(skip));
		write_reg(CFG_PAYLOAD_BYTES, TRACK_W'(payload));
		cfg_valid = 1'b0;
		cur_abs = first_sector;
		cur_frames = frames;
	endtask

	initial begin
		int ph, k;
		logic [TRACK_W-1:0] r_abs, r_frames, r_image;
		logic [FIH_W-1:0] r_fih;
		logic [PAY_W-1:0] r_pay;
		push = 1'b0;
		req_data = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TRACK_ABS_START;
		cfg_data = '0;
		// Assert reset after time zero so the flops see a falling edge.
		#1 arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings hold an empty track, so every request is empty.
		offer(make_req('0, '1));
		offer(make_req('1, 16'd1));

		// Small track: edges, zero count, hunk reuse and the chunk limit.
		program_track(20'd1000, 20'd200, 20'd5000, 8'd8, 5'd16, 12'd2048);
		offer(make_req(32'd1000, 16'd1));
		offer(make_req(32'd1001, 16'd2048));
		offer(make_req(32'd999, 16'd100));
		offer(make_req(32'd1200, 16'd100));
		offer(make_req(32'd1199, 16'd5000));
		offer(make_req(32'd1010, '0));
		offer(make_req(32'd1020, '1));
		offer(make_req('1, '1));

		// Widest track, zero frames per hunk, largest skip, payload above the cap.
		program_track('1, '1, '1, '0, '1, '1);
		offer(make_req('0, '1));
		offer(make_req(32'h000F_FFFE, '1));
		offer(make_req(32'h0010_0000 + 32'h000F_FFFE, '1));
		offer(make_req(32'h8000_0000, 16'd1));

		// Largest hunk: the run crosses the last frame slot of a hunk and
		// then leaves the track.
		program_track('1, 20'd64, 20'd12440, 8'd255, '0, 12'd2352);
		offer(make_req(32'h000F_FFFF + 32'd40, '1));
		offer(make_req(32'h000F_FFFF + 32'd63, 16'd3000));

		// Zero payload makes every request empty.
		program_track('0, 20'd1000, '0, 8'd4, '0, '0);
		offer(make_req(32'd5, 16'd100));

		// Short payload: the chunk limit cuts the request with bytes left.
		program_track('0, '1, 20'd7, 8'd16, 5'd24, 12'd1000);
		offer(make_req(32'd100, '1));
		offer(make_req(32'd3, 16'd999));

		for (ph = 0; ph < PHASES; ph++) begin
			r_abs = TRACK_W'($urandom);
			case ($urandom_range(2))
				0: r_frames = TRACK_W'($urandom_range(1, 200));
				1: r_frames = TRACK_W'($urandom);
				default: r_frames = '1;
			endcase
			r_image = TRACK_W'($urandom);
			case ($urandom_range(9))
				0: r_fih = '0;
				1, 2: r_fih = FIH_W'($urandom_range(17, 255));
				default: r_fih = FIH_W'($urandom_range(1, 16));
			endcase
			case ($urandom_range(6))
				0: r_pay = PAY_W'($urandom);
				1, 2: r_pay = PAY_W'($urandom_range(2048, 2352));
				3: r_pay = 12'd2352;
				4: r_pay = 12'd2336;
				5: r_pay = 12'd2324;
				default: r_pay = 12'd2048;
			endcase
			program_track(r_abs, r_frames, r_image, r_fih, SKIP_W'($urandom), r_pay);
			calm = (ph == 0);
			// The result side holds off while requests keep coming, so the
			// block fills up and stops taking requests.
			if (ph == 2)
				hold_orders++;
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (ph == 4 && k == ITEMS_PER_PHASE / 2)
					drain();
				offer(pick_request());
			end
		end

		drain();
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/csthm_pkg.sv
sv/csthm_front.sv
sv/csthm_queue.sv
sv/csthm_back.sv
sv/cd_sector_to_hunk_mapper_unit.sv
tb/cd_sector_to_hunk_mapper_unit_chunk_check.sv
tb/cd_sector_to_hunk_mapper_unit_test.sv
